FILE: design/cau_pkg.sv
`default_nettype none
package cau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam int QW = 16;

  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic              sat;
    logic signed [15:0] rr;
    logic signed [15:0] ri;
    logic              neg_r;
    logic              neg_i;
    logic              ovf_r;
    logic              ovf_i;
  } side_t;

endpackage
`default_nettype wire

FILE: design/cau_div_cell.sv
`default_nettype none
module cau_div_cell #(
  parameter int RW  = 58,
  parameter int DVW = 33,
  parameter int BIT = 15
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [RW-1:0]            rem_re_i,
  input  wire logic [RW-1:0]            rem_im_i,
  input  wire logic [DVW-1:0]           div_i,
  input  wire logic [cau_pkg::QW-1:0]   q_re_i,
  input  wire logic [cau_pkg::QW-1:0]   q_im_i,
  output logic      [RW-1:0]            rem_re_o,
  output logic      [RW-1:0]            rem_im_o,
  output logic      [DVW-1:0]           div_o,
  output logic      [cau_pkg::QW-1:0]   q_re_o,
  output logic      [cau_pkg::QW-1:0]   q_im_o
);

  logic [RW-1:0]          sh;
  logic                   ge_re, ge_im;
  logic [cau_pkg::QW-1:0] q_re_d, q_im_d;

  assign sh    = RW'(div_i) << BIT;
  assign ge_re = rem_re_i >= sh;
  assign ge_im = rem_im_i >= sh;

  always_comb begin
    q_re_d      = q_re_i;
    q_im_d      = q_im_i;
    q_re_d[BIT] = ge_re;
    q_im_d[BIT] = ge_im;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_re_o <= ge_re ? rem_re_i - sh : rem_re_i;
      rem_im_o <= ge_im ? rem_im_i - sh : rem_im_i;
      div_o    <= div_i;
      q_re_o   <= q_re_d;
      q_im_o   <= q_im_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/complex_arithmetic_unit_core.sv
// Complex add, subtract, multiply and divide on signed fixed-point parts with
// FRAC_BITS fractional bits. One beat is taken per cycle while the output side
// keeps up, and each beat passes through an input register, one row of
// 16x16 multipliers, a stage that forms sums and rounds, a row of 16
// restoring-division cells that each settle one quotient bit, and an output
// register. Every stage holds only when the stage after it is full and held,
// so gaps upstream are squeezed out. Results are clipped to 16 bits with the
// saturated flag set; divide by zero gives zero with divide_by_zero set.
`default_nettype none
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[1:0], a_real[17:2], a_imag[33:18], b_real[49:34], b_imag[65:50]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // res_real[15:0], res_imag[31:16], saturated[32], divide_by_zero[33]
  output logic      [39:0] m_axis_tdata
);

  localparam int NC  = cau_pkg::QW;
  localparam int NS  = NC + 4;
  localparam int RW  = 50 + FRAC_BITS;
  localparam int DVW = 33;
  localparam int RND = (FRAC_BITS == 0) ? 0 : (1 << (FRAC_BITS - 1));

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 0: input
  logic [1:0]         cmd0_q;
  logic signed [15:0] ar_q, ai_q, br_q, bi_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cmd0_q <= s_axis_tdata[1:0];
      ar_q   <= s_axis_tdata[17:2];
      ai_q   <= s_axis_tdata[33:18];
      br_q   <= s_axis_tdata[49:34];
      bi_q   <= s_axis_tdata[65:50];
    end
  end

  // stage 1: products, add and subtract
  logic [1:0]         cmd1_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, s_rr_q, s_ii_q;
  logic signed [15:0] as_r_q, as_i_q;
  logic               as_sat_q;
  logic signed [16:0] as_r, as_i;
  logic               ovr, ovi;

  always_comb begin
    if (cmd0_q == cau_pkg::CMD_SUB) begin
      as_r = 17'(ar_q) - 17'(br_q);
      as_i = 17'(ai_q) - 17'(bi_q);
    end else begin
      as_r = 17'(ar_q) + 17'(br_q);
      as_i = 17'(ai_q) + 17'(bi_q);
    end
    ovr = as_r[16] != as_r[15];
    ovi = as_i[16] != as_i[15];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cmd1_q   <= cmd0_q;
      p_rr_q   <= ar_q * br_q;
      p_ii_q   <= ai_q * bi_q;
      p_ri_q   <= ar_q * bi_q;
      p_ir_q   <= ai_q * br_q;
      s_rr_q   <= br_q * br_q;
      s_ii_q   <= bi_q * bi_q;
      as_r_q   <= ovr ? (as_r[16] ? 16'sh8000 : 16'sh7fff) : as_r[15:0];
      as_i_q   <= ovi ? (as_i[16] ? 16'sh8000 : 16'sh7fff) : as_i[15:0];
      as_sat_q <= ovr || ovi;
    end
  end

  // stage 2: sums, multiply rounding, divide setup
  logic signed [32:0] mr, mi, nr, ni;
  logic signed [33:0] myr, myi, msr, msi;
  logic [32:0]        den, mag_r, mag_i;
  logic [RW-1:0]      dd_r, dd_i, lim;
  logic [DVW-1:0]     dvs;
  logic               msat_r, msat_i;
  logic [15:0]        mres_r, mres_i;
  cau_pkg::side_t     sd;

  always_comb begin
    mr    = 33'(p_rr_q) - 33'(p_ii_q);
    mi    = 33'(p_ri_q) + 33'(p_ir_q);
    nr    = 33'(p_rr_q) + 33'(p_ii_q);
    ni    = 33'(p_ir_q) - 33'(p_ri_q);
    den   = 33'($unsigned(s_rr_q)) + 33'($unsigned(s_ii_q));
    myr   = 34'(mr) + 34'(RND);
    myi   = 34'(mi) + 34'(RND);
    msr   = myr >>> FRAC_BITS;
    msi   = myi >>> FRAC_BITS;
    msat_r = (msr > 34'sd32767) || (msr < -34'sd32768);
    msat_i = (msi > 34'sd32767) || (msi < -34'sd32768);
    mres_r = msat_r ? (msr[33] ? 16'h8000 : 16'h7fff) : msr[15:0];
    mres_i = msat_i ? (msi[33] ? 16'h8000 : 16'h7fff) : msi[15:0];
    mag_r = nr[32] ? 33'(-nr) : 33'(nr);
    mag_i = ni[32] ? 33'(-ni) : 33'(ni);
    dvs   = {den[31:0], 1'b0};
    dd_r  = (RW'(mag_r) << (FRAC_BITS + 1)) + RW'(den);
    dd_i  = (RW'(mag_i) << (FRAC_BITS + 1)) + RW'(den);
    lim   = RW'(dvs) << NC;

    sd.is_div = cmd1_q == cau_pkg::CMD_DIV;
    sd.dz     = den == '0;
    sd.neg_r  = nr[32];
    sd.neg_i  = ni[32];
    sd.ovf_r  = dd_r >= lim;
    sd.ovf_i  = dd_i >= lim;
    case (cmd1_q)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
        sd.rr  = as_r_q;
        sd.ri  = as_i_q;
        sd.sat = as_sat_q;
      end
      cau_pkg::CMD_MUL: begin
        sd.rr  = mres_r;
        sd.ri  = mres_i;
        sd.sat = msat_r || msat_i;
      end
      default: begin
        sd.rr  = '0;
        sd.ri  = '0;
        sd.sat = 1'b0;
      end
    endcase
  end

  logic [RW-1:0]  rem_re [0:NC];
  logic [RW-1:0]  rem_im [0:NC];
  logic [DVW-1:0] dv     [0:NC];
  logic [NC-1:0]  q_re   [0:NC];
  logic [NC-1:0]  q_im   [0:NC];
  cau_pkg::side_t side_q [0:NC];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rem_re[0] <= dd_r;
      rem_im[0] <= dd_i;
      dv[0]     <= dvs;
      q_re[0]   <= '0;
      q_im[0]   <= '0;
      side_q[0] <= sd;
    end
  end

  // stages 3 .. NC+2: one quotient bit per cell
  for (genvar c = 0; c < NC; c++) begin : g_cell
    cau_div_cell #(
      .RW  (RW),
      .DVW (DVW),
      .BIT (NC - 1 - c)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (en[c+3]),
      .rem_re_i (rem_re[c]),
      .rem_im_i (rem_im[c]),
      .div_i    (dv[c]),
      .q_re_i   (q_re[c]),
      .q_im_i   (q_im[c]),
      .rem_re_o (rem_re[c+1]),
      .rem_im_o (rem_im[c+1]),
      .div_o    (dv[c+1]),
      .q_re_o   (q_re[c+1]),
      .q_im_o   (q_im[c+1])
    );

    always_ff @(posedge clk_i) begin
      if (en[c+3]) begin
        side_q[c+1] <= side_q[c];
      end
    end
  end

  // last stage: sign, clip, output
  cau_pkg::side_t     sl;
  logic [NC-1:0]      qr, qi;
  logic               dsat_r, dsat_i;
  logic [15:0]        dres_r, dres_i;
  logic [15:0]        o_r, o_i;
  logic               o_sat, o_dz;
  logic [39:0]        out_q;

  always_comb begin
    sl = side_q[NC];
    qr = q_re[NC];
    qi = q_im[NC];
    if (sl.neg_r) begin
      dsat_r = sl.ovf_r || (qr > 16'd32768);
      dres_r = dsat_r ? 16'h8000 : 16'(-qr);
    end else begin
      dsat_r = sl.ovf_r || (qr > 16'd32767);
      dres_r = dsat_r ? 16'h7fff : qr;
    end
    if (sl.neg_i) begin
      dsat_i = sl.ovf_i || (qi > 16'd32768);
      dres_i = dsat_i ? 16'h8000 : 16'(-qi);
    end else begin
      dsat_i = sl.ovf_i || (qi > 16'd32767);
      dres_i = dsat_i ? 16'h7fff : qi;
    end
    if (!sl.is_div) begin
      o_r = sl.rr;
      o_i = sl.ri;
      o_sat = sl.sat;
      o_dz = 1'b0;
    end else if (sl.dz) begin
      o_r = '0;
      o_i = '0;
      o_sat = 1'b0;
      o_dz = 1'b1;
    end else begin
      o_r = dres_r;
      o_i = dres_i;
      o_sat = dsat_r || dsat_i;
      o_dz = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= {6'd0, o_dz, o_sat, o_i, o_r};
    end
  end

  assign m_axis_tdata = out_q;

endmodule
`default_nettype wire

FILE: test/tb_complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit_core;

  typedef struct {
    logic signed [15:0] res_real;
    logic signed [15:0] res_imag;
    logic               saturated;
    logic               divide_by_zero;
  } cplx_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  cplx_result_t pending_results[$];
  int  mismatch_count;
  int  result_count;
  int  item_count;
  int  op_count[4];
  bit  src_gaps;
  bit  sink_gaps;
  bit  sink_hold;
  int  sink_hold_cycles;

  complex_arithmetic_unit_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint clip16(input longint x, inout bit sat);
    if (x > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (x < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return x;
  endfunction

  // floor((x + half lsb) / 2^8)
  function automatic longint mul_round(input longint x);
    return (x + 128) >>> 8;
  endfunction

  function automatic longint div_round(input longint n, input longint d);
    longint mag;
    longint q;
    mag = (n < 0 ? -n : n) <<< 8;
    q = (2 * mag + d) / (2 * d);
    return n < 0 ? -q : q;
  endfunction

  function automatic cplx_result_t complex_result(input logic [1:0] cmd,
      input logic signed [15:0] ar, input logic signed [15:0] ai,
      input logic signed [15:0] br, input logic signed [15:0] bi);
    cplx_result_t r;
    longint xr, xi, yr, yi, rr, ri, den;
    bit sat;
    xr = ar; xi = ai; yr = br; yi = bi;
    rr = 0; ri = 0; sat = 1'b0;
    r.divide_by_zero = 1'b0;
    case (cmd)
      cau_pkg::CMD_ADD: begin
        rr = clip16(xr + yr, sat);
        ri = clip16(xi + yi, sat);
      end
      cau_pkg::CMD_SUB: begin
        rr = clip16(xr - yr, sat);
        ri = clip16(xi - yi, sat);
      end
      cau_pkg::CMD_MUL: begin
        rr = clip16(mul_round(xr * yr - xi * yi), sat);
        ri = clip16(mul_round(xr * yi + xi * yr), sat);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          rr = clip16(div_round(xr * yr + xi * yi, den), sat);
          ri = clip16(div_round(xi * yr - xr * yi, den), sat);
        end
      end
    endcase
    r.res_real = rr[15:0];
    r.res_imag = ri[15:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic send_operands(input logic [1:0] cmd, input logic [15:0] ar,
      input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {6'd0, bi, br, ai, ar, cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(complex_result(cmd, ar, ai, br, bi));
    item_count++;
    op_count[cmd]++;
    @(negedge clk_i);
  endtask

  task automatic idle_source();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_source();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] random_part();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      3: return 16'($urandom_range(0, 8)) << 8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [1:0] cmd;
    logic [15:0] br, bi;
    repeat (n) begin
      cmd = 2'($urandom_range(0, 3));
      br = random_part();
      bi = random_part();
      if (cmd == cau_pkg::CMD_DIV && $urandom_range(0, 19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_operands(cmd, random_part(), random_part(), br, bi);
    end
  endtask

  task automatic test_extremes();
    logic [15:0] vals[5];
    vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0100};
    for (int c = 0; c < 4; c++) begin
      send_operands(2'(c), vals[c], vals[c + 1], vals[4 - c], vals[(c + 2) % 5]);
      send_operands(2'(c), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_operands(2'(c), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_operands(2'(c), 16'h0180, 16'hfe80, 16'h0080, 16'h0100);
    end
    send_operands(cau_pkg::CMD_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    send_operands(cau_pkg::CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_operands(cau_pkg::CMD_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0001);
    send_operands(cau_pkg::CMD_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000);
    send_operands(cau_pkg::CMD_MUL, 16'hffff, 16'h0000, 16'h0080, 16'h0000);
    send_operands(cau_pkg::CMD_DIV, 16'h0001, 16'h0000, 16'h0200, 16'h0000);
    send_operands(cau_pkg::CMD_DIV, 16'hffff, 16'h0000, 16'h0200, 16'h0000);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    send_random(300);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    sink_hold_cycles = 200;
    sink_hold <= 1'b1;
    send_random(80);
    wait_drained();
  endtask

  task automatic test_random_gaps();
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    send_random(400);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    wait_drained();
    while (sink_hold) @(negedge clk_i);
  endtask

  task automatic test_full_rate_tail();
    send_random(120);
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (sink_hold) begin
      m_axis_tready <= 1'b0;
      if (sink_hold_cycles == 0) sink_hold <= 1'b0;
      else sink_hold_cycles--;
    end else if (sink_gaps && $urandom_range(0, 15) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_cycles = $urandom_range(1, 15);
      sink_hold <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cplx_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: %h", m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== exp_r.res_real
            || m_axis_tdata[31:16] !== exp_r.res_imag
            || m_axis_tdata[32] !== exp_r.saturated
            || m_axis_tdata[33] !== exp_r.divide_by_zero) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display(
              "result %0d: expected re=%h im=%h sat=%b dz=%b, got re=%h im=%h sat=%b dz=%b",
              result_count, exp_r.res_real, exp_r.res_imag, exp_r.saturated,
              exp_r.divide_by_zero, m_axis_tdata[15:0], m_axis_tdata[31:16],
              m_axis_tdata[32], m_axis_tdata[33]);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_complex_arithmetic_unit_core: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = 1'b0;
    sink_hold_cycles = 0;
    mismatch_count = 0;
    result_count = 0;
    item_count = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_back_to_back();
    test_output_backpressure();
    test_random_gaps();
    test_full_rate_tail();
    repeat (40) @(negedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;
    $display("covered %0d operand beats (add %0d, sub %0d, mul %0d, div %0d), %0d results",
             item_count, op_count[0], op_count[1], op_count[2], op_count[3], result_count);
    $display("with saturation, divide by zero, rounding ties, gaps and output stalls");
    if (mismatch_count == 0) begin
      $display("tb_complex_arithmetic_unit_core: done, clean");
    end else begin
      $display("tb_complex_arithmetic_unit_core: done, errors");
    end
    $finish;
  end

endmodule
